// ----- rtl/glzw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared constants, command and status types for the decoder core.
// ----------------------------------------------------------------------------
package glzw_pkg;

   localparam int TABLE_ENTRIES_DEF = 4096;
   localparam int MAX_CODE_BITS_DEF = 12;

   // widths of the datapath values that do not follow the parameters
   localparam int VAL_W  = 18;  // codes, clear code and next entry
   localparam int BUF_W  = 24;
   localparam int CNT_W  = 5;
   localparam int CW_W   = 5;
   localparam int LIM_W  = 32;
   localparam int MIN_W  = 4;
   localparam int PIX_W  = 31;
   localparam int CSR_IDX_W = 1;

   localparam int LIMIT_SLACK   = 256;
   localparam int MIN_SIZE_LOW  = 2;
   localparam int MIN_SIZE_HIGH = 11;
   localparam int RESET_MIN     = 8;
   localparam int RESET_PIXELS  = 65536;
   localparam int BYTE_ROOM     = 16;  // bytes accepted while at most this many bits held

   // request actions
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_END   = 2'd3;

   // status codes
   localparam logic [2:0] ST_DECODING  = 3'd0;
   localparam logic [2:0] ST_NEED_DATA = 3'd1;
   localparam logic [2:0] ST_END_CODE  = 3'd2;
   localparam logic [2:0] ST_INVALID   = 3'd3;
   localparam logic [2:0] ST_LIMIT     = 3'd4;
   localparam logic [2:0] ST_EXHAUSTED = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PIXELS = 1'd1;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_START = 4'd1;
   localparam logic [OP_W-1:0] OP_BYTE  = 4'd2;
   localparam logic [OP_W-1:0] OP_END   = 4'd3;
   localparam logic [OP_W-1:0] OP_POP   = 4'd4;
   localparam logic [OP_W-1:0] OP_DEC0  = 4'd5;
   localparam logic [OP_W-1:0] OP_DEC1  = 4'd6;
   localparam logic [OP_W-1:0] OP_WALK  = 4'd7;
   localparam logic [OP_W-1:0] OP_FIN   = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            new_item;
   } cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic can_decode;
      logic dec_go;
      logic limit_hit;
      logic walk_done;
   } sts_type;

endpackage

// ----- rtl/glzw_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW request channel
// Valid/ready channel carrying one action and an optional payload byte.
// ----------------------------------------------------------------------------
interface glzw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ----- rtl/glzw_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface glzw_rsp_if;
   logic       valid;
   logic       ready;
   logic       pixel_valid;
   logic [7:0] pixel_index;
   logic       byte_taken;
   logic [2:0] status;

   modport source (output valid, output pixel_valid, output pixel_index,
                   output byte_taken, output status, input ready);
   modport sink   (input valid, input pixel_valid, input pixel_index,
                   input byte_taken, input status, output ready);
endinterface

// ----- rtl/glzw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder datapath
// Bit buffer, string table, string stack and decode registers.
// ----------------------------------------------------------------------------
module glzw_datapath
   import glzw_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [7:0]           data_byte,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_wdata,
   output logic                 pixel_valid,
   output logic [7:0]           pixel_index,
   output logic                 byte_taken,
   output logic [2:0]           status
);

   localparam int TAB_AW    = $clog2(TABLE_ENTRIES);
   localparam int LEN_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int STK_DEPTH = TABLE_ENTRIES + 1;
   localparam int STK_AW    = $clog2(STK_DEPTH);
   localparam int DEP_W     = $clog2(STK_DEPTH + 1);
   localparam int ENT_W     = LEN_W + TAB_AW + 8;
   localparam logic [VAL_W-1:0] TAB_LIM = VAL_W'(TABLE_ENTRIES);
   localparam logic [VAL_W-1:0] RST_CLEAR = VAL_W'(1) << RESET_MIN;

   // configuration
   logic [MIN_W-1:0] cfg_min_ff, cfg_min_in;
   logic [PIX_W-1:0] cfg_pix_ff, cfg_pix_in;

   // decode state
   logic [MIN_W-1:0]  act_min_ff, act_min_in;
   logic [VAL_W-1:0]  clear_ff, clear_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CW_W-1:0]   cw_ff, cw_in;
   logic [VAL_W-1:0]  next_ff, next_in;
   logic [TAB_AW-1:0] prev_ff, prev_in;
   logic              prev_ok_ff, prev_ok_in;
   logic [LEN_W-1:0]  prev_len_ff, prev_len_in;
   logic [7:0]        prev_first_ff, prev_first_in;
   logic [DEP_W-1:0]  depth_ff, depth_in;
   logic [LIM_W-1:0]  prod_ff, prod_in;
   logic [2:0]        run_ff, run_in;
   logic              ended_ff, ended_in;
   logic              kwk_ff, kwk_in;
   logic [VAL_W-1:0]  code_ff, code_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [VAL_W-1:0]  walk_ff, walk_in;
   logic              taken_ff, taken_in;
   logic              popped_ff, popped_in;

   // response payload
   logic       pv_ff;
   logic [7:0] pix_ff;
   logic       bt_ff;
   logic [2:0] st_ff;

   // memories
   logic [ENT_W-1:0] tbl_mem [TABLE_ENTRIES];
   logic [ENT_W-1:0] tbl_q;
   logic [7:0]       stk_mem [STK_DEPTH];
   logic [7:0]       stk_q;

   logic              tbl_we;
   logic [TAB_AW-1:0] tbl_waddr, tbl_raddr;
   logic [ENT_W-1:0]  tbl_wdata;
   logic              stk_we;
   logic [STK_AW-1:0] stk_waddr, stk_raddr;
   logic [7:0]        stk_wdata;

   logic [LEN_W-1:0]  q_len;
   logic [TAB_AW-1:0] q_pre;
   logic [7:0]        q_suf;

   // start values
   logic             st_bad;
   logic [MIN_W-1:0] st_min;

   // code extraction
   logic [BUF_W-1:0] code_mask;
   logic [VAL_W-1:0] code_v;
   logic             have_code, is_end, is_clear, is_norm, is_kwk, dec_go;
   logic [VAL_W-1:0] walk_start;

   // limit check
   logic [LEN_W-1:0] d1_len;
   logic [LIM_W:0]   d1_sum;
   logic             limit_hit, kwk_push;

   // walk
   logic             walk_root, add_ok, grow;
   logic [VAL_W-1:0] next_inc;
   logic             stack_empty;

   assign {q_len, q_pre, q_suf} = tbl_q;
   assign stack_empty = (depth_ff == '0);

   always_comb begin
      st_bad = (cfg_min_ff < MIN_W'(MIN_SIZE_LOW)) || (cfg_min_ff > MIN_W'(MIN_SIZE_HIGH));
      if (cfg_min_ff < MIN_W'(MIN_SIZE_LOW)) begin
         st_min = MIN_W'(MIN_SIZE_LOW);
      end else if (cfg_min_ff > MIN_W'(MIN_SIZE_HIGH)) begin
         st_min = MIN_W'(MIN_SIZE_HIGH);
      end else begin
         st_min = cfg_min_ff;
      end
   end

   always_comb begin
      code_mask  = BUF_W'(((BUF_W + 1)'(1) << cw_ff) - (BUF_W + 1)'(1));
      code_v     = VAL_W'(buf_ff & code_mask);
      have_code  = (cnt_ff >= CNT_W'(cw_ff));
      is_end     = (code_v == clear_ff + VAL_W'(1));
      is_clear   = (code_v == clear_ff);
      is_norm    = (code_v < next_ff) && (code_v < TAB_LIM);
      is_kwk     = (code_v == next_ff) && prev_ok_ff && (code_v < TAB_LIM);
      dec_go     = have_code && !is_end && !is_clear && (is_norm || is_kwk);
      walk_start = is_kwk ? VAL_W'(prev_ff) : code_v;
   end

   always_comb begin
      if (kwk_ff) begin
         d1_len = prev_len_ff;
      end else if (code_ff < clear_ff) begin
         d1_len = LEN_W'(1);
      end else begin
         d1_len = q_len;
      end
      d1_sum    = {1'b0, prod_ff} + (LIM_W + 1)'(d1_len);
      limit_hit = (d1_sum > {1'b0, limit_ff});
      kwk_push  = kwk_ff && (d1_sum < {1'b0, limit_ff});
   end

   always_comb begin
      walk_root = (walk_ff < clear_ff);
      add_ok    = prev_ok_ff && (next_ff < TAB_LIM);
      next_inc  = next_ff + VAL_W'(1);
      grow      = (next_inc >= (VAL_W'(1) << cw_ff)) && (cw_ff < CW_W'(MAX_CODE_BITS));
   end

   assign sts.stack_empty = stack_empty;
   assign sts.can_decode  = (run_ff < ST_END_CODE);
   assign sts.dec_go      = dec_go;
   assign sts.limit_hit   = limit_hit;
   assign sts.walk_done   = walk_root;

   // memory ports
   always_comb begin
      case (cmd.op)
         OP_DEC0: tbl_raddr = walk_start[TAB_AW-1:0];
         OP_WALK: tbl_raddr = q_pre;
         default: tbl_raddr = walk_ff[TAB_AW-1:0];
      endcase
      tbl_we    = (cmd.op == OP_WALK) && walk_root && add_ok;
      tbl_waddr = next_ff[TAB_AW-1:0];
      tbl_wdata = {prev_len_ff + LEN_W'(1), prev_ff, walk_ff[7:0]};
      stk_waddr = depth_ff[STK_AW-1:0];
      stk_raddr = STK_AW'(depth_ff - DEP_W'(1));
      stk_we    = 1'b0;
      stk_wdata = walk_root ? walk_ff[7:0] : q_suf;
      if (cmd.op == OP_DEC1) begin
         stk_we    = !limit_hit && kwk_push;
         stk_wdata = prev_first_ff;
      end else if (cmd.op == OP_WALK) begin
         stk_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_q <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q <= stk_mem[stk_raddr];
   end

   // next state of the decode registers
   always_comb begin
      cfg_min_in    = cfg_min_ff;
      cfg_pix_in    = cfg_pix_ff;
      act_min_in    = act_min_ff;
      clear_in      = clear_ff;
      limit_in      = limit_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      cw_in         = cw_ff;
      next_in       = next_ff;
      prev_in       = prev_ff;
      prev_ok_in    = prev_ok_ff;
      prev_len_in   = prev_len_ff;
      prev_first_in = prev_first_ff;
      depth_in      = depth_ff;
      prod_in       = prod_ff;
      run_in        = run_ff;
      ended_in      = ended_ff;
      kwk_in        = kwk_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      walk_in       = walk_ff;
      taken_in      = cmd.new_item ? 1'b0 : taken_ff;
      popped_in     = cmd.new_item ? 1'b0 : popped_ff;

      if (csr_we) begin
         if (csr_index == CSR_CODE_SIZE) begin
            cfg_min_in = csr_wdata[MIN_W-1:0];
         end else if (csr_index == CSR_FRAME_PIXELS) begin
            cfg_pix_in = csr_wdata;
         end
      end

      case (cmd.op)
         OP_START: begin
            act_min_in = st_min;
            clear_in   = VAL_W'(1) << st_min;
            limit_in   = LIM_W'(cfg_pix_ff) + LIM_W'(LIMIT_SLACK);
            buf_in     = '0;
            cnt_in     = '0;
            cw_in      = CW_W'(st_min) + CW_W'(1);
            next_in    = (VAL_W'(1) << st_min) + VAL_W'(2);
            prev_in    = '0;
            prev_ok_in = 1'b0;
            depth_in   = '0;
            prod_in    = '0;
            run_in     = st_bad ? ST_INVALID : ST_DECODING;
            ended_in   = 1'b0;
         end
         OP_BYTE: begin
            if (run_ff >= ST_END_CODE || ended_ff) begin
               taken_in = 1'b1;  // dropped
            end else if (cnt_ff <= CNT_W'(BYTE_ROOM)) begin
               buf_in   = buf_ff | BUF_W'({16'd0, data_byte} << cnt_ff);
               cnt_in   = cnt_ff + CNT_W'(8);
               taken_in = 1'b1;
               if (run_ff == ST_NEED_DATA) begin
                  run_in = ST_DECODING;
               end
            end
         end
         OP_END: begin
            ended_in = 1'b1;
         end
         OP_POP: begin
            if (!stack_empty) begin
               depth_in  = depth_ff - DEP_W'(1);
               popped_in = 1'b1;
            end
         end
         OP_DEC0: begin
            if (!have_code) begin
               run_in = ended_ff ? ST_EXHAUSTED : ST_NEED_DATA;
            end else begin
               buf_in  = buf_ff >> cw_ff;
               cnt_in  = cnt_ff - CNT_W'(cw_ff);
               run_in  = ST_DECODING;
               kwk_in  = is_kwk && !is_norm;
               code_in = code_v;
               walk_in = walk_start;
               if (is_end) begin
                  run_in = ST_END_CODE;
               end else if (is_clear) begin
                  cw_in      = CW_W'(act_min_ff) + CW_W'(1);
                  next_in    = clear_ff + VAL_W'(2);
                  prev_ok_in = 1'b0;
               end else if (!is_norm && !is_kwk) begin
                  run_in = ST_INVALID;
               end
            end
         end
         OP_DEC1: begin
            if (limit_hit) begin
               run_in = ST_LIMIT;
            end else begin
               if (kwk_push) begin
                  depth_in = depth_ff + DEP_W'(1);
                  prod_in  = LIM_W'(d1_sum) + LIM_W'(1);
               end else begin
                  prod_in  = LIM_W'(d1_sum);
               end
               len_in = kwk_ff ? prev_len_ff + LEN_W'(1) : d1_len;
            end
         end
         OP_WALK: begin
            depth_in = depth_ff + DEP_W'(1);
            if (walk_root) begin
               if (add_ok) begin
                  next_in = next_inc;
                  if (grow) begin
                     cw_in = cw_ff + CW_W'(1);
                  end
               end
               prev_in       = code_ff[TAB_AW-1:0];
               prev_len_in   = len_ff;
               prev_first_in = walk_ff[7:0];
               prev_ok_in    = 1'b1;
            end else begin
               walk_in = VAL_W'(q_pre);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_ff <= MIN_W'(RESET_MIN);
         cfg_pix_ff <= PIX_W'(RESET_PIXELS);
         act_min_ff <= MIN_W'(RESET_MIN);
         clear_ff   <= RST_CLEAR;
         limit_ff   <= LIM_W'(RESET_PIXELS + LIMIT_SLACK);
         buf_ff     <= '0;
         cnt_ff     <= '0;
         cw_ff      <= CW_W'(RESET_MIN + 1);
         next_ff    <= RST_CLEAR + VAL_W'(2);
         prev_ok_ff <= 1'b0;
         depth_ff   <= '0;
         prod_ff    <= '0;
         run_ff     <= ST_DECODING;
         ended_ff   <= 1'b0;
         taken_ff   <= 1'b0;
         popped_ff  <= 1'b0;
      end else begin
         cfg_min_ff <= cfg_min_in;
         cfg_pix_ff <= cfg_pix_in;
         act_min_ff <= act_min_in;
         clear_ff   <= clear_in;
         limit_ff   <= limit_in;
         buf_ff     <= buf_in;
         cnt_ff     <= cnt_in;
         cw_ff      <= cw_in;
         next_ff    <= next_in;
         prev_ok_ff <= prev_ok_in;
         depth_ff   <= depth_in;
         prod_ff    <= prod_in;
         run_ff     <= run_in;
         ended_ff   <= ended_in;
         taken_ff   <= taken_in;
         popped_ff  <= popped_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      prev_len_ff   <= prev_len_in;
      prev_first_ff <= prev_first_in;
      kwk_ff        <= kwk_in;
      code_ff       <= code_in;
      len_ff        <= len_in;
      walk_ff       <= walk_in;
      if (cmd.op == OP_FIN) begin
         pv_ff  <= popped_ff;
         pix_ff <= popped_ff ? stk_q : 8'd0;
         bt_ff  <= taken_ff;
         st_ff  <= run_ff;
      end
   end

   assign pixel_valid = pv_ff;
   assign pixel_index = pix_ff;
   assign byte_taken  = bt_ff;
   assign status      = st_ff;

`ifndef ASSERT_OFF
   a_bits_held: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUF_W))
      else $error("bit count beyond buffer");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEP_W'(STK_DEPTH))
      else $error("string stack overrun");

   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      (next_ff <= TAB_LIM) || (next_ff == clear_ff + VAL_W'(2)))
      else $error("next entry beyond table");

   a_walk_stores: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_WALK) |=> (depth_ff == $past(depth_ff) + DEP_W'(1)))
      else $error("walk step without stack push");
`endif

endmodule

// ----- rtl/glzw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder controller
// Sequences each request to its response; a decoding tick goes through decode, string walk and pop.
// ----------------------------------------------------------------------------
module glzw_ctrl
   import glzw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  sts_type    sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC1 = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_ready && req_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.new_item = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.new_item = 1'b1;
               state_in     = S_FIN;
               case (req_action)
                  ACT_START: cmd.op = OP_START;
                  ACT_BYTE:  cmd.op = OP_BYTE;
                  ACT_END:   cmd.op = OP_END;
                  default: begin
                     if (!sts.stack_empty) begin
                        cmd.op = OP_POP;
                     end else if (sts.can_decode) begin
                        cmd.op = OP_DEC0;
                        if (sts.dec_go) begin
                           state_in = S_DEC1;
                        end
                     end
                  end
               endcase
            end
         end
         S_DEC1: begin
            cmd.op   = OP_DEC1;
            state_in = sts.limit_hit ? S_FIN : S_WALK;
         end
         S_WALK: begin
            cmd.op = OP_WALK;
            if (sts.walk_done) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.op   = OP_POP;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op       = OP_FIN;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside finish step");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while item in progress");

   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) && $past(state_ff != S_WALK) |-> $past(state_ff == S_DEC1))
      else $error("walk entered without limit check");
`endif

endmodule

// ----- rtl/gif_lzw_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder core
// Variable-width LZW decoder, codes least significant bit first.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_chan (valid/ready) with an action: start,
// data byte, tick or end of data. Every request gives exactly one response
// on rsp_chan carrying pixel_valid, pixel_index, byte_taken and status.
// The minimum code size and frame pixel count registers are written on the
// csr_ port and take effect at the next start.
// Steps: start, byte, end and a tick that pops a buffered pixel go
// straight to the finish step and the response. A tick that decodes a
// code runs the decode, limit check, string walk, pop and finish steps;
// the string walk reads one table entry per cycle from the string table
// and pushes it on the stack. The remaining pixels of a string then pop
// one per tick. One request is in flight at a time;
// a new one is taken in the cycle the previous response transfers.
// Reset acts as a start with min code size 8 and 65536 pixels; no table
// clearing pass is needed. When the receiver stalls the response holds and
// no further request is taken.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_core
   import glzw_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   glzw_req_if.sink             req_chan,
   glzw_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   glzw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_action (req_chan.action),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   glzw_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .data_byte   (req_chan.data_byte),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pixel_valid (rsp_chan.pixel_valid),
      .pixel_index (rsp_chan.pixel_index),
      .byte_taken  (rsp_chan.byte_taken),
      .status      (rsp_chan.status)
   );

endmodule
